@@ rtl/calendar_date_add_days_macros.svh @@
// Assertion macros for the calendar date adder checker.
// Used by cda_checker.sv; expects clk_i and rst_ni in the enclosing scope.
`ifndef CALENDAR_DATE_ADD_DAYS_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CDA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/cda_pkg.sv @@
// Shared constants and calendar helper functions for the date adder.
// No dependencies; imported by every module of the block.
package cda_pkg;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int IN_YEAR_W = 14;
  localparam int YEAR_W    = 15;   // working year, covers start year plus the walk
  localparam int DAYS_W    = 16;   // width of the days_to_add port
  localparam int DOY_W     = 9;    // day of year, 1..366
  localparam int R_W       = 9;    // year modulo 400

  localparam logic [DOY_W-1:0]   DAYS_LEAP   = 9'd366;
  localparam logic [DOY_W-1:0]   DAYS_COMMON = 9'd365;
  localparam logic [R_W-1:0]     CYCLE_LAST  = 9'd399;
  localparam logic [R_W-1:0]     CENT_1      = 9'd100;
  localparam logic [R_W-1:0]     CENT_2      = 9'd200;
  localparam logic [R_W-1:0]     CENT_3      = 9'd300;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

  // Year modulo 400 by restoring subtraction of 400 * 2^k.
  function automatic logic [R_W-1:0] year_mod400(input logic [IN_YEAR_W-1:0] y);
    logic [IN_YEAR_W-1:0] v;
    logic [IN_YEAR_W-1:0] step;
    v = y;
    for (int i = 5; i >= 0; i--) begin
      step = IN_YEAR_W'(400) << i;
      if (v >= step) begin
        v = v - step;
      end
    end
    return v[R_W-1:0];
  endfunction

  // Leap rule from the year's position in the 400-year cycle.
  function automatic logic is_leap(input logic [R_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
  endfunction

  function automatic logic [R_W-1:0] next_mod400(input logic [R_W-1:0] r);
    return (r == CYCLE_LAST) ? '0 : r + 1'b1;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days in the months before m in a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/cda_front.sv @@
// Front end: accepts an item, checks the start date and folds the day count
// into a (year, day count) pair for the back end. Depends on cda_pkg.
module cda_front import cda_pkg::*; #(
  parameter int ADD_W = 16,
  parameter int CNT_W = 17
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DAY_W-1:0]     start_day_i,
  input  logic [MONTH_W-1:0]   start_month_i,
  input  logic [IN_YEAR_W-1:0] start_year_i,
  input  logic [DAYS_W-1:0]    days_to_add_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic                 ok_o,
  output logic [YEAR_W-1:0]    year_o,
  output logic [R_W-1:0]       mod400_o,
  output logic [CNT_W-1:0]     cnt_o
);

  logic [R_W-1:0]   r;
  logic             leap;
  logic [DAY_W-1:0] mlen;
  logic [DOY_W-1:0] doy;
  logic [DOY_W-1:0] rem;
  logic [CNT_W-1:0] add_ext;
  logic [CNT_W-1:0] rem_ext;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    r    = year_mod400(start_year_i);
    leap = is_leap(r);
    mlen = month_days(start_month_i, leap);
    ok_o = (start_month_i >= MONTH_JAN) && (start_month_i <= MONTH_DEC) &&
           (start_day_i != '0) && (start_day_i <= mlen);
    doy  = days_before(start_month_i) + DOY_W'(start_day_i) +
           DOY_W'(leap && (start_month_i > MONTH_FEB));
    rem  = (leap ? DAYS_LEAP : DAYS_COMMON) - doy;
    add_ext = CNT_W'(days_to_add_i[ADD_W-1:0]);
    rem_ext = CNT_W'(rem);
    // Stay in the start year when the count fits, else move to January 1st
    // of the next year and carry what is left.
    if (add_ext <= rem_ext) begin
      cnt_o    = CNT_W'(doy) + add_ext;
      year_o   = YEAR_W'(start_year_i);
      mod400_o = r;
    end else begin
      cnt_o    = add_ext - rem_ext;
      year_o   = YEAR_W'(start_year_i) + 1'b1;
      mod400_o = next_mod400(r);
    end
  end

endmodule

@@ rtl/cda_queue.sv @@
// Two-entry queue between front and back end.
// Depends on cda_pkg only for style consistency of the import.
module cda_queue import cda_pkg::*; #(
  parameter int WIDTH = 42
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/cda_back.sv @@
// Back end: walks whole years, then months, and holds the result register.
// Depends on cda_pkg.
module cda_back import cda_pkg::*; #(
  parameter int CNT_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  logic                 ok_i,
  input  logic [YEAR_W-1:0]    year_i,
  input  logic [R_W-1:0]       mod400_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DAY_W-1:0]     result_day_o,
  output logic [MONTH_W-1:0]   result_month_o,
  output logic [IN_YEAR_W-1:0] result_year_o,
  output logic                 date_valid_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_YEAR, ST_MONTH} state_e;

  state_e               state_q, state_d;
  logic                 ok_q, ok_d;
  logic [YEAR_W-1:0]    year_q, year_d;
  logic [R_W-1:0]       r_q, r_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic                 out_valid_q, out_valid_d;
  logic [DAY_W-1:0]     day_out_q, day_out_d;
  logic [MONTH_W-1:0]   month_out_q, month_out_d;
  logic [IN_YEAR_W-1:0] year_out_q, year_out_d;
  logic                 valid_out_q, valid_out_d;
  logic                 leap;
  logic [CNT_W-1:0]     diy;
  logic [CNT_W-1:0]     mlen;

  always_comb begin
    leap = is_leap(r_q);
    diy  = CNT_W'(leap ? DAYS_LEAP : DAYS_COMMON);
    mlen = CNT_W'(month_days(month_q, leap));

    state_d     = state_q;
    ok_d        = ok_q;
    year_d      = year_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    month_d     = month_q;
    day_out_d   = day_out_q;
    month_out_d = month_out_q;
    year_out_d  = year_out_q;
    valid_out_d = valid_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ok_d    = ok_i;
          year_d  = year_i;
          r_d     = mod400_i;
          cnt_d   = cnt_i;
          month_d = MONTH_JAN;
          state_d = ok_i ? ST_YEAR : ST_MONTH;
        end
      end
      ST_YEAR: begin
        // Advance one whole year per cycle while the count overruns it.
        if (cnt_q > diy) begin
          cnt_d  = cnt_q - diy;
          year_d = year_q + 1'b1;
          r_d    = next_mod400(r_q);
        end else begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ok_q && (month_q < MONTH_DEC) && (cnt_q > mlen)) begin
          cnt_d   = cnt_q - mlen;
          month_d = month_q + 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          valid_out_d = ok_q;
          day_out_d   = ok_q ? cnt_q[DAY_W-1:0] : '0;
          month_out_d = ok_q ? month_q : '0;
          year_out_d  = ok_q ? year_q[IN_YEAR_W-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      year_q      <= '0;
      r_q         <= '0;
      cnt_q       <= '0;
      month_q     <= '0;
      day_out_q   <= '0;
      month_out_q <= '0;
      year_out_q  <= '0;
      valid_out_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      year_q      <= year_d;
      r_q         <= r_d;
      cnt_q       <= cnt_d;
      month_q     <= month_d;
      day_out_q   <= day_out_d;
      month_out_q <= month_out_d;
      year_out_q  <= year_out_d;
      valid_out_q <= valid_out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_day_o   = day_out_q;
  assign result_month_o = month_out_q;
  assign result_year_o  = year_out_q;
  assign date_valid_o   = valid_out_q;

endmodule

@@ rtl/calendar_date_add_days.sv @@
// Gregorian date plus a count of days: top level.
// Instantiates cda_front, cda_queue and cda_back; depends on cda_pkg.
//
// Usage: the input channel (in_valid_i / in_ready_o) takes a start date and
// a day count; the output channel (out_valid_o / out_ready_i) returns one
// result item per input item, in order. An invalid start date (month outside
// 1..12 or day outside the month) gives a zero date with date_valid_o low.
// Only the low ADD_BITS bits of days_to_add_i (at most 16) are used.
// From acceptance, the back end loads the item, steps whole years (fewer
// than days/365, up to 179 for a 16-bit count), leaves the year walk, makes
// up to 11 month steps and fills the output register; an invalid start date
// skips the year and month steps. The back end takes the next item on the
// cycle after it fills the output register, so it finishes one item before
// it starts the next and the year walk sets the rate. The front keeps
// accepting into a two-entry queue meanwhile; in_ready_o drops only when
// that queue is full.
// A stalled receiver holds the result register; the back end then holds its
// finished item until the register frees. Reset empties the queue and drops
// any item at work or waiting on the output.
module calendar_date_add_days import cda_pkg::*; #(
  parameter int ADD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DAY_W-1:0]     start_day_i,
  input  logic [MONTH_W-1:0]   start_month_i,
  input  logic [IN_YEAR_W-1:0] start_year_i,
  input  logic [DAYS_W-1:0]    days_to_add_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DAY_W-1:0]     result_day_o,
  output logic [MONTH_W-1:0]   result_month_o,
  output logic [IN_YEAR_W-1:0] result_year_o,
  output logic                 date_valid_o
);

  // Count bits that matter, and the working width of the day counter.
  localparam int ADD_W   = (ADD_BITS < DAYS_W) ? ADD_BITS : DAYS_W;
  localparam int CNT_W   = ((ADD_W > DOY_W) ? ADD_W : DOY_W) + 1;
  localparam int ENTRY_W = 1 + YEAR_W + R_W + CNT_W;

  logic               push, full, pop, empty;
  logic               f_ok, b_ok;
  logic [YEAR_W-1:0]  f_year, b_year;
  logic [R_W-1:0]     f_r, b_r;
  logic [CNT_W-1:0]   f_cnt, b_cnt;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // Classify and fold the start date as the item arrives.
  cda_front #(
    .ADD_W (ADD_W),
    .CNT_W (CNT_W)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .days_to_add_i (days_to_add_i),
    .full_i        (full),
    .push_o        (push),
    .ok_o          (f_ok),
    .year_o        (f_year),
    .mod400_o      (f_r),
    .cnt_o         (f_cnt)
  );

  assign q_wdata = {f_ok, f_year, f_r, f_cnt};

  // Decouple the front from the long-running back end.
  cda_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  assign {b_ok, b_year, b_r, b_cnt} = q_rdata;

  // Walk years and months, then hand the date to the output register.
  cda_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .ok_i           (b_ok),
    .year_i         (b_year),
    .mod400_i       (b_r),
    .cnt_i          (b_cnt),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .date_valid_o   (date_valid_o)
  );

endmodule

@@ rtl/cda_checker.sv @@
// Port-level checker for the calendar date adder, bound to the top level.
// Depends on cda_pkg and calendar_date_add_days_macros.svh.
`include "calendar_date_add_days_macros.svh"

module cda_checker import cda_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [DAY_W-1:0]     start_day_i,
  input logic [MONTH_W-1:0]   start_month_i,
  input logic [IN_YEAR_W-1:0] start_year_i,
  input logic [DAYS_W-1:0]    days_to_add_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [DAY_W-1:0]     result_day_o,
  input logic [MONTH_W-1:0]   result_month_o,
  input logic [IN_YEAR_W-1:0] result_year_o,
  input logic                 date_valid_o
);

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track items taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  `CDA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_day_o) && $stable(result_month_o) && $stable(result_year_o) && $stable(date_valid_o), "output item changed while stalled")
  `CDA_ASSERT_NEVER(a_no_invented, out_valid_o && (pending_q == '0), "result without an accepted item")
  `CDA_ASSERT(a_invalid_zero, out_valid_o && !date_valid_o |-> (result_day_o == '0) && (result_month_o == '0) && (result_year_o == '0), "invalid result not cleared")
  `CDA_ASSERT(a_valid_range, out_valid_o && date_valid_o |-> (result_month_o >= MONTH_JAN) && (result_month_o <= MONTH_DEC) && (result_day_o != '0) && (result_day_o <= month_days(result_month_o, 1'b1)), "result date out of range")

endmodule

bind calendar_date_add_days cda_checker u_cda_checker (.*);

@@ test/calendar_date_add_days_test.sv @@
// Self-checking testbench for calendar_date_add_days: a table of dates and then random ones,
// checked against typed table results or a behavioral date adder kept in this file.
// Depends on cda_pkg and the calendar_date_add_days RTL.
module calendar_date_add_days_test;
  import cda_pkg::*;

  localparam int ADD_BITS       = 16;
  localparam int RANDOM_ITEMS   = 550;
  localparam int RESET_CYCLES   = 7;
  localparam int HOLD_OFF       = 400;   // long receiver stall that fills the block
  localparam int HOLD_AFTER     = 40;    // results to see before that stall
  localparam int TAIL_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on either side

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [IN_YEAR_W-1:0] year;
    logic                 valid;
  } date_result_t;

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [IN_YEAR_W-1:0] year;
    logic [DAYS_W-1:0]    days;
    logic                 typed;   // want holds the expected result
    date_result_t         want;
  } date_request_t;

  localparam int DIRECTED_ROWS = 25;

  // Directed rows: zero day counts, month and year rollovers, leap and century rules,
  // invalid starts, and the largest counts from the first and last years.
  date_request_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{5'd1,  4'd1,  14'd2000, 16'd0,     1'b1, '{5'd1,  4'd1,  14'd2000, 1'b1}},
    '{5'd31, 4'd12, 14'd1999, 16'd1,     1'b1, '{5'd1,  4'd1,  14'd2000, 1'b1}},
    '{5'd29, 4'd2,  14'd2000, 16'd0,     1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1}},
    '{5'd29, 4'd2,  14'd1900, 16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd29, 4'd2,  14'd2024, 16'd1,     1'b1, '{5'd1,  4'd3,  14'd2024, 1'b1}},
    '{5'd28, 4'd2,  14'd2023, 16'd1,     1'b1, '{5'd1,  4'd3,  14'd2023, 1'b1}},
    '{5'd28, 4'd2,  14'd2100, 16'd1,     1'b1, '{5'd1,  4'd3,  14'd2100, 1'b1}},
    '{5'd0,  4'd1,  14'd2000, 16'd5,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd31, 4'd4,  14'd2000, 16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd30, 4'd2,  14'd2000, 16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd1,  4'd0,  14'd2000, 16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd1,  4'd13, 14'd2000, 16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd31, 4'd15, 14'd9999, 16'd65535, 1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd0,  4'd0,  14'd0,    16'd0,     1'b1, '{5'd0,  4'd0,  14'd0,    1'b0}},
    '{5'd1,  4'd1,  14'd0,    16'd0,     1'b1, '{5'd1,  4'd1,  14'd0,    1'b1}},
    '{5'd29, 4'd2,  14'd0,    16'd0,     1'b1, '{5'd29, 4'd2,  14'd0,    1'b1}},
    '{5'd1,  4'd1,  14'd2001, 16'd365,   1'b1, '{5'd1,  4'd1,  14'd2002, 1'b1}},
    '{5'd1,  4'd1,  14'd2000, 16'd366,   1'b1, '{5'd1,  4'd1,  14'd2001, 1'b1}},
    '{5'd31, 4'd12, 14'd2000, 16'd0,     1'b1, '{5'd31, 4'd12, 14'd2000, 1'b1}},
    '{5'd31, 4'd1,  14'd9999, 16'd0,     1'b1, '{5'd31, 4'd1,  14'd9999, 1'b1}},
    '{5'd31, 4'd12, 14'd9999, 16'd65535, 1'b0, '0},
    '{5'd1,  4'd1,  14'd0,    16'd65535, 1'b0, '0},
    '{5'd1,  4'd1,  14'd2000, 16'd65535, 1'b0, '0},
    '{5'd15, 4'd6,  14'd1600, 16'd1000,  1'b0, '0},
    '{5'd31, 4'd12, 14'd2023, 16'd366,   1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [DAY_W-1:0]     start_day_i;
  logic [MONTH_W-1:0]   start_month_i;
  logic [IN_YEAR_W-1:0] start_year_i;
  logic [DAYS_W-1:0]    days_to_add_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DAY_W-1:0]     result_day_o;
  logic [MONTH_W-1:0]   result_month_o;
  logic [IN_YEAR_W-1:0] result_year_o;
  logic                 date_valid_o;

  date_result_t expected_dates [$];
  date_result_t offered_date;     // expectation for the item now on the input
  int           mismatch_count = 0;
  int           checked_count  = 0;
  int           quiet_cycles   = 0;

  calendar_date_add_days #(
    .ADD_BITS(ADD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .days_to_add_i  (days_to_add_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .date_valid_o   (date_valid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Gregorian leap rule, applied to year 0 and beyond 9999 alike.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MONTH_FEB:             return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int unsigned year_length(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // Start date plus a day count: day of year, whole years, then the month walk.
  function automatic date_result_t add_days_to_date(date_request_t q);
    date_result_t r;
    int unsigned  year;
    int unsigned  doy;
    int unsigned  rest;
    int unsigned  pos;
    int unsigned  add;
    int unsigned  mon;
    r    = '0;
    year = q.year;
    add  = q.days & ((32'd1 << ADD_BITS) - 1);
    if (q.month < MONTH_JAN || q.month > MONTH_DEC || q.day < 1 ||
        q.day > month_length(q.month, year)) begin
      return r;
    end
    doy = q.day;
    for (mon = MONTH_JAN; mon < q.month; mon++) begin
      doy += month_length(mon, year);
    end
    rest = year_length(year) - doy;
    if (add <= rest) begin
      pos = doy + add;
    end else begin
      // Finish the start year, then step whole years while more than one remains.
      add -= rest;
      year++;
      while (add > year_length(year)) begin
        add -= year_length(year);
        year++;
      end
      pos = add;
    end
    for (mon = MONTH_JAN; mon < MONTH_DEC; mon++) begin
      if (pos <= month_length(mon, year)) break;
      pos -= month_length(mon, year);
    end
    r.day   = DAY_W'(pos);
    r.month = MONTH_W'(mon);
    r.year  = IN_YEAR_W'(year);
    r.valid = 1'b1;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Mostly well-formed dates, a fair share on the last day of a month; the rest raw noise
  // in which many months and days are out of range.
  function automatic date_request_t random_request();
    date_request_t q;
    int unsigned   pick;
    int unsigned   lim;
    q    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      q.day   = DAY_W'($urandom_range(0, 31));
      q.month = MONTH_W'($urandom_range(0, 15));
      q.year  = IN_YEAR_W'($urandom_range(0, 9999));
      q.days  = DAYS_W'($urandom_range(0, 65535));
      return q;
    end
    q.month = MONTH_W'($urandom_range(1, 12));
    q.year  = IN_YEAR_W'($urandom_range(0, 9999));
    lim     = month_length(q.month, q.year);
    q.day   = DAY_W'((pick < 32) ? lim : $urandom_range(1, lim));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: q.days = DAYS_W'($urandom_range(0, 1500));
      4, 5, 6:    q.days = DAYS_W'($urandom_range(0, 65535));
      7:          q.days = DAYS_W'(65535 - $urandom_range(0, 600));
      8:          q.days = DAYS_W'($urandom_range(0, 40));
      default:    q.days = DAYS_W'($urandom_range(362, 369));
    endcase
    return q;
  endfunction

  // Offer one item after an optional gap and hold it until accepted.
  // Leaves off at the falling edge after the accepting rising edge.
  task automatic offer_date(date_request_t q);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    offered_date   = q.typed ? q.want : add_days_to_date(q);
    in_valid_i    <= 1'b1;
    start_day_i   <= q.day;
    start_month_i <= q.month;
    start_year_i  <= q.year;
    days_to_add_i <= q.days;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Stimulus: reset, the table, then random items; drain and give the verdict.
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    start_day_i   = '0;
    start_month_i = '0;
    start_year_i  = '0;
    days_to_add_i = '0;
    offered_date  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_date(directed_rows[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      offer_date(random_request());
    end
    in_valid_i <= 1'b0;
    // Wait for every expected date, then for stray results past the last one.
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_dates.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_dates.size());
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: ready runs and stalls of random length, plus one long hold-off once
  // results are flowing so the queue fills and in_ready_o drops.
  initial begin
    bit          held;
    int unsigned hold;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && checked_count >= HOLD_AFTER) begin
        held         = 1'b1;
        out_ready_i <= 1'b0;
        hold         = HOLD_OFF;
      end else begin
        hold = idle_len();
        if (hold > 0) begin
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          hold         = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 20);
        end
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  // Monitor: check each result against the oldest expectation, then record the item
  // accepted at this edge. Also count cycles with no handshake for the watchdog.
  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_count++;
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no item pending: day %0d month %0d year %0d valid %0b",
                   $time, result_day_o, result_month_o, result_year_o, date_valid_o);
        end else begin
          want = expected_dates.pop_front();
          compare_field("result_day",   want.day,   result_day_o);
          compare_field("result_month", want.month, result_month_o);
          compare_field("result_year",  want.year,  result_year_o);
          compare_field("date_valid",   want.valid, date_valid_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_dates.push_back(offered_date);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cda_pkg.sv
rtl/cda_front.sv
rtl/cda_queue.sv
rtl/cda_back.sv
rtl/calendar_date_add_days.sv
rtl/cda_checker.sv
test/calendar_date_add_days_test.sv
